### design/pmx_pkg.sv
// ----------------------------------------------------------------------------
// pmx_pkg
// Shared constants and types for the partially mapped crossover block.
// ----------------------------------------------------------------------------
package pmx_pkg;

  // A city number is six bits, so a segment map is indexed by all 64 cities.
  localparam int CITY_W     = 6;
  localparam int CITY_COUNT = 64;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;

  // Control from the sequencer to one mapping chain unit.
  typedef struct packed {
    logic clear;   // invalidate every map entry
    logic wr_en;   // write one map entry
    logic start;   // load a new walk start city
    logic step;    // follow the map one hop if the current entry is valid
  } chain_ctl_t;

endpackage

### design/pmx_chain.sv
// ----------------------------------------------------------------------------
// pmx_chain
// One segment map (city to city) with per-entry valid bits and a walker
// that follows the map one hop per cycle while step is high and the entry is valid.
// ----------------------------------------------------------------------------
module pmx_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  pmx_pkg::chain_ctl_t        ctl,
  input  logic [pmx_pkg::CITY_W-1:0] wr_city,
  input  logic [pmx_pkg::CITY_W-1:0] wr_map,
  input  logic [pmx_pkg::CITY_W-1:0] start_city,
  output logic [pmx_pkg::CITY_W-1:0] city,
  output logic                       more
);

  logic [pmx_pkg::CITY_W-1:0] map_mem [pmx_pkg::CITY_COUNT];
  logic [pmx_pkg::CITY_COUNT-1:0] vld;
  logic [pmx_pkg::CITY_W-1:0] cur;
  logic [pmx_pkg::CITY_W-1:0] rdata;
  logic [pmx_pkg::CITY_W-1:0] raddr;

  // The read data holds the map entry of the current city for as long as the
  // walker moves on each step, so the next address is the entry just read.
  assign raddr = ctl.start ? start_city : rdata;
  assign more  = vld[cur];
  assign city  = cur;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      map_mem[wr_city] <= wr_map;
    end
    rdata <= map_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.clear) begin
      vld <= '0;
    end else if (ctl.wr_en) begin
      vld[wr_city] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cur <= start_city;
    end else if (ctl.step && more) begin
      cur <= rdata;
    end
  end

endmodule

### design/pmx_permutation_crossover_top.sv
// ----------------------------------------------------------------------------
// pmx_permutation_crossover_top
// Partially mapped crossover of two parent permutations of up to MAX_CITIES
// cities, built by a small sequencer around two map walkers on one control word.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries one parent element pair per item; s_tlast
// marks the final pair and carries the two cut points. A run ends early when
// MAX_CITIES pairs have been loaded. Loading accepts one item per cycle.
// After the final item the block drops s_tready and works: it clears both
// maps, fills them over the segment through S_FILL_RD and S_FILL_WR per
// position, then produces one child pair per position on the master stream,
// m_tlast on the final one, via S_EMIT_RD, S_EMIT_CHK and S_OUT. A position
// outside the segment also walks in S_WALK, up to MAX_CITIES + 1 map hops, set
// by the longer of the two repair chains walked in lockstep.
// Each result waits in the output register until m_tready; a stalled receiver
// simply holds the sequencer. s_tready returns in the cycle after the final
// result is taken. Reset returns the block to loading with an empty run and
// all map entries invalid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pmx_permutation_crossover_top #(
  parameter int MAX_CITIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [5:0] father_city, [11:6] mother_city, [17:12] and [23:18] the two cut points, in either order
  input  logic [pmx_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [5:0] child_one_city, [11:6] child_two_city, [15:12] zero
  output logic [pmx_pkg::M_DATA_W-1:0] m_tdata,
  output logic                         m_tlast
);

  localparam int IDX_W     = $clog2(MAX_CITIES);
  localparam int HOP_W     = $clog2(MAX_CITIES + 2);
  localparam int HOP_LIMIT = MAX_CITIES + 1;
  localparam int CW        = pmx_pkg::CITY_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FILL_RD,
    S_FILL_WR,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_WALK,
    S_OUT
  } state_t;

  state_t state;

  logic [CW-1:0] father_mem [MAX_CITIES];
  logic [CW-1:0] mother_mem [MAX_CITIES];
  logic [CW-1:0] fdata;
  logic [CW-1:0] mdata;

  logic [IDX_W-1:0] load_count;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic [IDX_W-1:0] last_pos;
  logic [HOP_W-1:0] hops;

  logic [CW-1:0] child_one;
  logic [CW-1:0] child_two;

  logic             in_acc;
  logic             in_last;
  logic [CW-1:0]    in_father;
  logic [CW-1:0]    in_mother;
  logic [CW-1:0]    cut_a;
  logic [CW-1:0]    cut_b;
  logic [IDX_W-1:0] sat_a;
  logic [IDX_W-1:0] sat_b;
  logic             hop_ok;
  logic             in_seg;

  pmx_pkg::chain_ctl_t ctl_one;
  pmx_pkg::chain_ctl_t ctl_two;
  logic [CW-1:0]       city_one;
  logic [CW-1:0]       city_two;
  logic                more_one;
  logic                more_two;

  assign s_tready  = (state == S_LOAD);
  assign in_acc    = s_tvalid && s_tready;
  assign in_father = s_tdata[5:0];
  assign in_mother = s_tdata[11:6];
  assign cut_a     = s_tdata[17:12];
  assign cut_b     = s_tdata[23:18];
  assign in_last   = s_tlast || (load_count == IDX_W'(MAX_CITIES - 1));

  // Cuts past the final position saturate to it.
  assign sat_a = (cut_a > CW'(load_count)) ? load_count : cut_a[IDX_W-1:0];
  assign sat_b = (cut_b > CW'(load_count)) ? load_count : cut_b[IDX_W-1:0];

  assign hop_ok = (hops < HOP_W'(HOP_LIMIT));
  assign in_seg = (idx >= lo) && (idx <= hi);

  assign m_tdata = {{(pmx_pkg::M_DATA_W - 2 * CW){1'b0}}, child_two, child_one};

  // Child 1 repairs through the father-to-mother map, child 2 through the
  // reverse map.
  always_comb begin
    ctl_one.clear = in_acc && in_last;
    ctl_one.wr_en = (state == S_FILL_WR);
    ctl_one.start = (state == S_EMIT_CHK) && !in_seg;
    ctl_one.step  = (state == S_WALK) && hop_ok;
    ctl_two       = ctl_one;
  end

  pmx_chain u_f2m (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_one),
    .wr_city    (fdata),
    .wr_map     (mdata),
    .start_city (mdata),
    .city       (city_one),
    .more       (more_one)
  );

  pmx_chain u_m2f (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_two),
    .wr_city    (mdata),
    .wr_map     (fdata),
    .start_city (fdata),
    .city       (city_two),
    .more       (more_two)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      father_mem[load_count] <= in_father;
      mother_mem[load_count] <= in_mother;
    end
    fdata <= father_mem[idx];
    mdata <= mother_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (in_last) begin
              load_count <= '0;
              last_pos   <= load_count;
              if (sat_a > sat_b) begin
                lo  <= sat_b;
                hi  <= sat_a;
                idx <= sat_b;
              end else begin
                lo  <= sat_a;
                hi  <= sat_b;
                idx <= sat_a;
              end
              state <= S_FILL_RD;
            end else begin
              load_count <= load_count + 1'b1;
            end
          end
        end
        S_FILL_RD: begin
          state <= S_FILL_WR;
        end
        S_FILL_WR: begin
          if (idx == hi) begin
            idx   <= '0;
            state <= S_EMIT_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FILL_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_CHK;
        end
        S_EMIT_CHK: begin
          if (in_seg) begin
            child_one <= fdata;
            child_two <= mdata;
            m_tlast   <= (idx == last_pos);
            m_tvalid  <= 1'b1;
            state     <= S_OUT;
          end else begin
            hops  <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (hop_ok && (more_one || more_two)) begin
            hops <= hops + 1'b1;
          end else begin
            child_one <= city_one;
            child_two <= city_two;
            m_tlast   <= (idx == last_pos);
            m_tvalid  <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (idx == last_pos) begin
              state <= S_LOAD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

### design/pmx_checker.sv
// ----------------------------------------------------------------------------
// pmx_checker
// Port-level checks for the crossover block, bound to its top level.
// ----------------------------------------------------------------------------
module pmx_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         s_tlast,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [pmx_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         m_tlast
);

  // Loading and result delivery never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // An item with s_tlast stops further loading while the children are built.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still ready after the final item");

  // Taking the final result returns the block to loading.
  a_ready_after_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not back to loading after the final result");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind pmx_permutation_crossover_top pmx_checker u_pmx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
